>>> src/ire_pkg.sv
// shared constants and arctangent table for the imu rate and tilt engine
package ire_pkg;

    // field widths
    localparam int RAW_W   = 16;
    localparam int RATE_W  = 20;
    localparam int ACC_W   = 25;
    localparam int ROLL_W  = 25;
    localparam int PITCH_W = 24;

    // cordic working widths
    localparam int CORD_IN_W  = 25;
    localparam int CORD_XY_W  = 36;
    localparam int CORD_ACC_W = 34;

    // default iteration count of the vectoring unit
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    // saturation limits
    localparam logic signed [25:0] ACC_LIMIT   = 26'sd10283125;
    localparam logic signed [33:0] ROLL_LIMIT  = 34'sd11796480;
    localparam logic signed [33:0] PITCH_LIMIT = 34'sd5898240;

    // 90 degrees in q.24
    localparam logic signed [33:0] DEG90_Q24 = 34'sd1509949440;

    // scaling constants
    localparam logic signed [27:0] GYRO_BASE  = 28'sd250;
    localparam logic signed [42:0] ACC_SCALE  = 43'sd1961330;
    localparam logic signed [42:0] ACC_ROUND  = 43'sd50000;
    localparam logic signed [42:0] ACC_OFFSET = 43'sd1677721600000;
    localparam logic signed [25:0] Q_OFFSET   = 26'sd16777216;
    localparam logic [17:0]        DIV_CONST  = 18'd100000;
    localparam int                 DIV_BITS   = 42;

    // sum of squares must exceed this for a tilt update
    localparam logic [48:0] MAG_THRESH = 49'd42949672;

    // arctangent of 2^-i in q.24 degrees
    function automatic logic signed [33:0] atan_q24(input logic [4:0] idx);
        logic signed [33:0] v;
        begin
            unique case (idx)
                5'd0:    v = 34'sd754974720;
                5'd1:    v = 34'sd445687602;
                5'd2:    v = 34'sd235489088;
                5'd3:    v = 34'sd119537938;
                5'd4:    v = 34'sd60000934;
                5'd5:    v = 34'sd30029717;
                5'd6:    v = 34'sd15018523;
                5'd7:    v = 34'sd7509720;
                5'd8:    v = 34'sd3754917;
                5'd9:    v = 34'sd1877466;
                5'd10:   v = 34'sd938734;
                5'd11:   v = 34'sd469367;
                5'd12:   v = 34'sd234684;
                5'd13:   v = 34'sd117342;
                5'd14:   v = 34'sd58671;
                5'd15:   v = 34'sd29335;
                5'd16:   v = 34'sd14668;
                5'd17:   v = 34'sd7334;
                5'd18:   v = 34'sd3667;
                5'd19:   v = 34'sd1833;
                5'd20:   v = 34'sd917;
                5'd21:   v = 34'sd458;
                5'd22:   v = 34'sd229;
                5'd23:   v = 34'sd115;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/ire_cordic.sv
// iterative cordic vectoring unit: atan2(y, x) in q.24 degrees, one rotation per cycle
module ire_cordic #(
    parameter int STEPS = ire_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [ire_pkg::CORD_IN_W-1:0]   x_in,
    input  logic signed [ire_pkg::CORD_IN_W-1:0]   y_in,
    output logic                                   done,
    output logic signed [ire_pkg::CORD_ACC_W-1:0]  angle
);

    localparam int NSTEP = (STEPS > ire_pkg::CORDIC_STEPS_MAX) ? ire_pkg::CORDIC_STEPS_MAX : STEPS;
    localparam logic [4:0] LAST = 5'(NSTEP - 1);

    logic signed [ire_pkg::CORD_XY_W-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ire_pkg::CORD_ACC_W-1:0] acc_reg, acc_next;
    logic [4:0]                            i_reg, i_next;
    logic                                  busy_reg, busy_next;
    logic                                  zero_reg, zero_next;
    logic                                  done_reg, done_next;

    logic signed [ire_pkg::CORD_XY_W-1:0]  xs, ys, dx, dy;
    logic signed [ire_pkg::CORD_ACC_W-1:0] at;

    // scaled inputs and shifted terms
    always_comb
    begin
        xs = {{3{x_in[ire_pkg::CORD_IN_W-1]}}, x_in, 8'd0};
        ys = {{3{y_in[ire_pkg::CORD_IN_W-1]}}, y_in, 8'd0};
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = ire_pkg::atan_q24(i_reg);
    end

    // load with quadrant fold, then one micro-rotation per cycle
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            busy_next = 1'b1;
            i_next    = 5'd0;
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_next   = ys;
                    y_next   = -xs;
                    acc_next = ire_pkg::DEG90_Q24;
                end
                else
                begin
                    x_next   = -ys;
                    y_next   = xs;
                    acc_next = -ire_pkg::DEG90_Q24;
                end
            end
            else
            begin
                x_next   = xs;
                y_next   = ys;
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next   = x_reg + dx;
                y_next   = y_reg - dy;
                acc_next = acc_reg + at;
            end
            else
            begin
                x_next   = x_reg - dx;
                y_next   = y_reg + dy;
                acc_next = acc_reg - at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : acc_reg;

endmodule

>>> src/imu_rate_and_tilt_engine_top.sv
// top level of the imu rate and tilt engine: scaling, magnitude test, square root and tilt
//
// usage:
//   s_* takes one six-axis sample per item; s_tuser carries the bus-ok flag.
//   m_* delivers exactly one result item per sample: rates, accelerations and
//   tilt angles, with sample-valid and tilt-updated flags in m_tuser.
//   cfg_we/cfg_index/cfg_data write the gyro (index 0) and accel (index 1)
//   range selects; write them only while the block is idle.
// sequence:
//   a bus failure goes straight to the output. otherwise each item is scaled, divided
//   by 100000 bit-serially, clamped, squared axis by axis and compared with the
//   threshold; a small magnitude then goes to the output. a full tilt update adds the
//   bit-serial square root, the start and run of the two vectoring units side by side,
//   and the output. one item is worked at a time; s_tready is high when idle.
// reset:
//   ranges return to 500 deg/s and 4 g, all held results return to zero.
// stall:
//   the result sits in an output register, so the next item is taken while it
//   waits; a finished item waits in the last state until that register frees.
module imu_rate_and_tilt_engine_top #(
    parameter int CORDIC_STEPS = ire_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [1:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [95:0]  s_tdata,
    // bus_ok
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // roll_rate, pitch_rate, yaw_rate, accel_x_si, accel_y_si, accel_z_si,
    // roll_angle, pitch_angle
    output logic [183:0] m_tdata,
    // sample_valid, tilt_updated
    output logic [1:0]   m_tuser
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_MUL  = 10'b0000000010,
        ST_DIV  = 10'b0000000100,
        ST_ACC  = 10'b0000001000,
        ST_SQR  = 10'b0000010000,
        ST_CHK  = 10'b0000100000,
        ST_ROOT = 10'b0001000000,
        ST_CST  = 10'b0010000000,
        ST_CORD = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } state_t;

    localparam int CFG_GYRO  = 0;
    localparam int CFG_ACCEL = 1;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [1:0] gsel_reg, asel_reg;
    logic       ok_reg, upd_reg;
    logic       out_valid_reg;
    logic [183:0] out_data_reg;
    logic [1:0]   out_user_reg;

    logic [ire_pkg::RAW_W-1:0] acc_raw_reg [3];
    logic [ire_pkg::RAW_W-1:0] gyr_raw_reg [3];

    logic signed [ire_pkg::RATE_W-1:0]  held_rates_reg  [3];
    logic signed [ire_pkg::ACC_W-1:0]   held_accels_reg [3];
    logic signed [ire_pkg::ROLL_W-1:0]  held_roll_reg;
    logic signed [ire_pkg::PITCH_W-1:0] held_pitch_reg;

    logic [ire_pkg::DIV_BITS-1:0] div_reg [3];
    logic [16:0]                  rem_reg [3];

    logic [48:0] sum_reg;
    logic [47:0] syz_reg;
    logic [47:0] rad_reg;
    logic [24:0] srem_reg;
    logic [23:0] root_reg;

    logic in_acc, out_load;
    logic cord_start, roll_done, pitch_done;
    logic signed [ire_pkg::CORD_ACC_W-1:0] roll_a, pitch_a;

    // squarer operand and product
    logic signed [ire_pkg::ACC_W-1:0] sq_op;
    logic signed [49:0]               sq_full;
    logic [46:0]                      sq;

    // square root step
    logic [26:0] rem_t, trial;
    logic        root_ge;

    // angle conversion
    logic signed [33:0] roll_q16, pitch_q16;

    function automatic logic signed [ire_pkg::ACC_W-1:0] clamp_acc(input logic signed [25:0] v);
        logic signed [25:0] r;
        begin
            if (v > ire_pkg::ACC_LIMIT)
                r = ire_pkg::ACC_LIMIT;
            else if (v < -ire_pkg::ACC_LIMIT)
                r = -ire_pkg::ACC_LIMIT;
            else
                r = v;
            return r[ire_pkg::ACC_W-1:0];
        end
    endfunction

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    assign cord_start = (state_reg == ST_CST);

    // squares share one multiplier
    always_comb
    begin
        sq_op   = held_accels_reg[cnt_reg[1:0]];
        sq_full = sq_op * sq_op;
        sq      = sq_full[46:0];
    end

    // one root bit per cycle
    always_comb
    begin
        rem_t   = {srem_reg, rad_reg[47:46]};
        trial   = {1'b0, root_reg, 2'b01};
        root_ge = (rem_t >= trial);
    end

    // q.24 to q.16 with rounding
    always_comb
    begin
        roll_q16  = (roll_a + 34'sd128) >>> 8;
        pitch_q16 = (pitch_a + 34'sd128) >>> 8;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = s_tuser[0] ? ST_MUL : ST_FIN;
            end
            ST_MUL:
            begin
                cnt_next   = 6'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ire_pkg::DIV_BITS - 1))
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cnt_next   = 6'd0;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cnt_next   = 6'd0;
                state_next = (sum_reg > ire_pkg::MAG_THRESH) ? ST_ROOT : ST_FIN;
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd23)
                    state_next = ST_CST;
            end
            ST_CST:
            begin
                state_next = ST_CORD;
            end
            ST_CORD:
            begin
                if (roll_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and held results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 6'd0;
            gsel_reg       <= 2'd1;
            asel_reg       <= 2'd1;
            ok_reg         <= 1'b0;
            upd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_roll_reg  <= '0;
            held_pitch_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                held_rates_reg[k]  <= '0;
                held_accels_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            // configuration writes
            if (cfg_we)
            begin
                if (cfg_index == 1'(CFG_GYRO))
                    gsel_reg <= cfg_data;
                else if (cfg_index == 1'(CFG_ACCEL))
                    asel_reg <= cfg_data;
            end

            if (in_acc)
            begin
                ok_reg  <= s_tuser[0];
                upd_reg <= 1'b0;
            end

            // gyro scaling
            if (state_reg == ST_MUL)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic signed [27:0] rp;
                    rp = ($signed({{12{gyr_raw_reg[k][15]}}, gyr_raw_reg[k]}) *
                          ire_pkg::GYRO_BASE) <<< gsel_reg;
                    rp = (rp + 28'sd64) >>> 7;
                    held_rates_reg[k] <= rp[ire_pkg::RATE_W-1:0];
                end
            end

            // quotient to signed acceleration
            if (state_reg == ST_ACC)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    held_accels_reg[k] <= clamp_acc($signed({1'b0, div_reg[k][24:0]}) -
                                                    ire_pkg::Q_OFFSET);
                end
            end

            // angle results
            if ((state_reg == ST_CORD) && roll_done && pitch_done)
            begin
                upd_reg <= 1'b1;
                if (roll_q16 > ire_pkg::ROLL_LIMIT)
                    held_roll_reg <= ire_pkg::ROLL_LIMIT[ire_pkg::ROLL_W-1:0];
                else if (roll_q16 < -ire_pkg::ROLL_LIMIT)
                    held_roll_reg <= -ire_pkg::ROLL_LIMIT[ire_pkg::ROLL_W-1:0];
                else
                    held_roll_reg <= roll_q16[ire_pkg::ROLL_W-1:0];
                if (pitch_q16 > ire_pkg::PITCH_LIMIT)
                    held_pitch_reg <= ire_pkg::PITCH_LIMIT[ire_pkg::PITCH_W-1:0];
                else if (pitch_q16 < -ire_pkg::PITCH_LIMIT)
                    held_pitch_reg <= -ire_pkg::PITCH_LIMIT[ire_pkg::PITCH_W-1:0];
                else
                    held_pitch_reg <= pitch_q16[ire_pkg::PITCH_W-1:0];
            end

            // output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc_raw_reg[k] <= s_tdata[16*k +: 16];
                gyr_raw_reg[k] <= s_tdata[48 + 16*k +: 16];
            end
        end

        // offset dividend so the restoring divide stays unsigned
        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [42:0] ap;
                ap = ($signed({{27{acc_raw_reg[k][15]}}, acc_raw_reg[k]}) *
                      ire_pkg::ACC_SCALE) <<< ({1'b0, asel_reg} + 3'd1);
                ap = ap + ire_pkg::ACC_ROUND + ire_pkg::ACC_OFFSET;
                div_reg[k] <= ap[ire_pkg::DIV_BITS-1:0];
                rem_reg[k] <= '0;
            end
        end

        // bit-serial divide by 100000, one quotient bit per cycle
        if (state_reg == ST_DIV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [17:0] t;
                logic        ge;
                t  = {rem_reg[k], div_reg[k][ire_pkg::DIV_BITS-1]};
                ge = (t >= ire_pkg::DIV_CONST);
                rem_reg[k] <= ge ? 17'(t - ire_pkg::DIV_CONST) : t[16:0];
                div_reg[k] <= {div_reg[k][ire_pkg::DIV_BITS-2:0], ge};
            end
        end

        // sum of squares, with y and z kept apart for the root
        if (state_reg == ST_SQR)
        begin
            if (cnt_reg == 6'd0)
            begin
                sum_reg <= {2'b00, sq};
            end
            else if (cnt_reg == 6'd1)
            begin
                sum_reg <= sum_reg + {2'b00, sq};
                syz_reg <= {1'b0, sq};
            end
            else
            begin
                sum_reg <= sum_reg + {2'b00, sq};
                syz_reg <= syz_reg + {1'b0, sq};
            end
        end

        // bit-serial square root
        if (state_reg == ST_CHK)
        begin
            rad_reg  <= syz_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_ROOT)
        begin
            rad_reg  <= {rad_reg[45:0], 2'b00};
            srem_reg <= root_ge ? 25'(rem_t - trial) : rem_t[24:0];
            root_reg <= {root_reg[22:0], root_ge};
        end

        if (out_load)
        begin
            out_user_reg <= {upd_reg, ok_reg};
            out_data_reg <= {held_pitch_reg, held_roll_reg,
                             held_accels_reg[2], held_accels_reg[1], held_accels_reg[0],
                             held_rates_reg[2], held_rates_reg[1], held_rates_reg[0]};
        end
    end

    // roll = atan2(y, z)
    ire_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (held_accels_reg[2]),
        .y_in  (held_accels_reg[1]),
        .done  (roll_done),
        .angle (roll_a)
    );

    // pitch = atan2(-x, sqrt(y^2 + z^2))
    ire_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  ({1'b0, root_reg}),
        .y_in  (-held_accels_reg[0]),
        .done  (pitch_done),
        .angle (pitch_a)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
